// ===== src/lpl_pkg.sv =====
`default_nettype none

package lpl_pkg;

  // Fixed widths of the transaction fields.
  localparam int KEY_W    = 32;
  localparam int SLOT_W   = 9;
  localparam int STATUS_W = 2;

  // A slot holding this key is empty.
  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

  localparam int DEF_TABLE_SLOTS = 257;

  // Home slot reduction steps: partial product, quotient, remainder.
  localparam int DIV_STEPS = 3;

  localparam int QUEUE_DEPTH = 2;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_CLEARED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_READ,
    B_CHECK,
    B_CLR,
    B_RESP
  } back_state_e;

endpackage

`default_nettype wire

// ===== src/lpl_front.sv =====
`default_nettype none

module lpl_front #(
  parameter int TABLE_SLOTS = lpl_pkg::DEF_TABLE_SLOTS,
  localparam int SW = $clog2(TABLE_SLOTS),
  localparam int QW = 1 + lpl_pkg::KEY_W + SW
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     kind_i,
  input  wire logic [lpl_pkg::KEY_W-1:0] key_i,
  input  wire logic                     init_busy_i,
  input  wire logic                     q_full_i,
  output logic                          q_push_o,
  output logic [QW-1:0]                 q_data_o
);

  localparam int KW    = lpl_pkg::KEY_W;
  localparam int PW    = 2 * KW + 1;
  localparam int LW    = KW + 16;
  localparam int CNT_W = $clog2(lpl_pkg::DIV_STEPS);

  // Reciprocal of the table size scaled by 2^(KW + SW) and rounded up. The
  // rounding error stays below 2^SW, so the quotient is exact for every key.
  localparam logic [63:0] RECIP =
    ((64'd1 << (KW + SW)) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
  localparam logic [16:0] RECIP_HI = RECIP[32:16];
  localparam logic [15:0] RECIP_LO = RECIP[15:0];

  lpl_pkg::front_state_e state_q, state_d;

  logic                      kind_q;
  logic [lpl_pkg::KEY_W-1:0] key_q;
  logic [LW-1:0]             lo_q, lo_d;
  logic [KW-1:0]             quot_q, quot_d;
  logic [KW-1:0]             diff;
  logic [SW-1:0]             rem_q, rem_d;
  logic [CNT_W-1:0]          step_q;
  logic                      accept;
  logic                      last_step;

  assign accept    = in_valid_i && in_ready_o;
  assign last_step = (step_q == CNT_W'(lpl_pkg::DIV_STEPS - 1));

  // The key times the reciprocal is split into a low and a high partial
  // product; the quotient then gives the remainder by one multiply-subtract.
  always_comb begin
    logic [PW-1:0] prod;
    lo_d   = LW'(key_q) * LW'(RECIP_LO);
    prod   = ((PW'(key_q) * PW'(RECIP_HI)) << 16) + PW'(lo_q);
    quot_d = KW'(prod >> (KW + SW));
    diff   = key_q - KW'(quot_q * KW'(TABLE_SLOTS));
    rem_d  = SW'(diff);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpl_pkg::F_IDLE: begin
        if (accept) begin
          state_d = (kind_i == lpl_pkg::KIND_CLEAR) ? lpl_pkg::F_PUSH : lpl_pkg::F_DIV;
        end
      end
      lpl_pkg::F_DIV: begin
        if (last_step) begin
          state_d = lpl_pkg::F_PUSH;
        end
      end
      lpl_pkg::F_PUSH: begin
        if (!q_full_i) begin
          state_d = lpl_pkg::F_IDLE;
        end
      end
      default: state_d = lpl_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    q_push_o   = 1'b0;
    unique case (state_q)
      lpl_pkg::F_IDLE: in_ready_o = !init_busy_i;
      lpl_pkg::F_DIV:  ;
      lpl_pkg::F_PUSH: q_push_o = !q_full_i;
      default:         ;
    endcase
  end

  assign q_data_o = {kind_q, key_q, rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpl_pkg::F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (state_q == lpl_pkg::F_DIV) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // The partial product and the quotient settle one stage per cycle; the
  // remainder is taken on the last step, once the quotient is final.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      rem_q  <= '0;
    end else if (state_q == lpl_pkg::F_DIV) begin
      lo_q   <= lo_d;
      quot_q <= quot_d;
      if (last_step) begin
        rem_q <= rem_d;
      end
    end
  end

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lpl_pkg::F_PUSH |-> rem_q < SW'(TABLE_SLOTS - 1) || rem_q == SW'(TABLE_SLOTS - 1))
    else $error("home slot remainder out of range");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lpl_pkg::F_DIV && last_step |=> state_q == lpl_pkg::F_PUSH)
    else $error("reduction did not hand over after its last step");

endmodule

`default_nettype wire

// ===== src/lpl_queue.sv =====
`default_nettype none

module lpl_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = lpl_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/lpl_back.sv =====
`default_nettype none

module lpl_back #(
  parameter int TABLE_SLOTS = lpl_pkg::DEF_TABLE_SLOTS,
  localparam int SW = $clog2(TABLE_SLOTS),
  localparam int QW = 1 + lpl_pkg::KEY_W + SW
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  wire logic [QW-1:0]                q_data_i,
  output logic                              q_pop_o,
  output logic                              init_busy_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [lpl_pkg::SLOT_W-1:0]        slot_o,
  output logic [lpl_pkg::STATUS_W-1:0]      status_o
);

  localparam logic [SW-1:0] LAST = SW'(TABLE_SLOTS - 1);

  lpl_pkg::back_state_e state_q, state_d;

  logic [lpl_pkg::KEY_W-1:0] mem [TABLE_SLOTS];
  logic [lpl_pkg::KEY_W-1:0] rdata_q;

  logic                      q_kind;
  logic [lpl_pkg::KEY_W-1:0] q_key;
  logic [SW-1:0]             q_home;

  logic [lpl_pkg::KEY_W-1:0] key_q;
  logic [SW-1:0]             home_q;
  logic [SW-1:0]             pos_q;
  logic [SW-1:0]             n_q;
  logic [SW-1:0]             clr_cnt_q;

  logic [SW-1:0]             res_slot_q;
  lpl_pkg::status_e          res_status_q;

  logic                      out_valid_q;
  logic [lpl_pkg::SLOT_W-1:0] slot_q;
  lpl_pkg::status_e          status_q;

  logic                      hit, empty, probes_done, clr_last;
  logic                      mem_we, out_load;
  logic [SW-1:0]             mem_addr;
  logic [lpl_pkg::KEY_W-1:0] mem_wdata;

  assign q_kind = q_data_i[lpl_pkg::KEY_W + SW];
  assign q_key  = q_data_i[lpl_pkg::KEY_W + SW - 1:SW];
  assign q_home = q_data_i[SW-1:0];

  assign hit         = (rdata_q == key_q);
  assign empty       = (rdata_q == lpl_pkg::EMPTY_KEY);
  assign probes_done = (n_q == LAST);
  assign clr_last    = (clr_cnt_q == LAST);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpl_pkg::B_INIT: begin
        if (clr_last) begin
          state_d = lpl_pkg::B_IDLE;
        end
      end
      lpl_pkg::B_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_kind == lpl_pkg::KIND_CLEAR) ? lpl_pkg::B_CLR : lpl_pkg::B_READ;
        end
      end
      lpl_pkg::B_READ:  state_d = lpl_pkg::B_CHECK;
      lpl_pkg::B_CHECK: begin
        if (hit || empty || probes_done) begin
          state_d = lpl_pkg::B_RESP;
        end else begin
          state_d = lpl_pkg::B_READ;
        end
      end
      lpl_pkg::B_CLR: begin
        if (clr_last) begin
          state_d = lpl_pkg::B_RESP;
        end
      end
      lpl_pkg::B_RESP: begin
        if (out_load) begin
          state_d = lpl_pkg::B_IDLE;
        end
      end
      default: state_d = lpl_pkg::B_INIT;
    endcase
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_addr    = clr_cnt_q;
    mem_wdata   = lpl_pkg::EMPTY_KEY;
    q_pop_o     = 1'b0;
    init_busy_o = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      lpl_pkg::B_INIT: begin
        mem_we      = 1'b1;
        init_busy_o = 1'b1;
      end
      lpl_pkg::B_IDLE:  q_pop_o = q_valid_i;
      lpl_pkg::B_READ:  ;
      lpl_pkg::B_CHECK: begin
        mem_addr  = pos_q;
        mem_wdata = key_q;
        mem_we    = !hit && empty;
      end
      lpl_pkg::B_CLR:   mem_we = 1'b1;
      lpl_pkg::B_RESP:  out_load = !out_valid_q || out_ready_i;
      default:          ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[pos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpl_pkg::B_INIT;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lpl_pkg::B_INIT || state_q == lpl_pkg::B_CLR) begin
        clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      key_q  <= q_key;
      home_q <= q_home;
      pos_q  <= q_home;
      n_q    <= '0;
    end else if (state_q == lpl_pkg::B_CHECK) begin
      pos_q <= (pos_q == LAST) ? '0 : pos_q + 1'b1;
      n_q   <= n_q + 1'b1;
    end
    if (state_q == lpl_pkg::B_CHECK) begin
      if (hit) begin
        res_slot_q   <= pos_q;
        res_status_q <= lpl_pkg::ST_FOUND;
      end else if (empty) begin
        res_slot_q   <= pos_q;
        res_status_q <= lpl_pkg::ST_INSERTED;
      end else begin
        res_slot_q   <= home_q;
        res_status_q <= lpl_pkg::ST_FULL;
      end
    end else if (state_q == lpl_pkg::B_CLR) begin
      res_slot_q   <= '0;
      res_status_q <= lpl_pkg::ST_CLEARED;
    end
    if (out_load) begin
      slot_q   <= lpl_pkg::SLOT_W'(res_slot_q);
      status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign status_o    = status_q;

  a_idle_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lpl_pkg::B_IDLE |-> $past(state_q) == lpl_pkg::B_INIT ||
      $past(state_q) == lpl_pkg::B_RESP || $past(state_q) == lpl_pkg::B_IDLE)
    else $error("sequencer reached idle from a working state");

  a_first_probe_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lpl_pkg::B_CHECK && n_q == '0 |-> pos_q == home_q)
    else $error("first probe is not at the home slot");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lpl_pkg::B_CHECK |-> pos_q < LAST || pos_q == LAST)
    else $error("probe position beyond the table");

  a_clear_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == lpl_pkg::ST_CLEARED |-> slot_q == '0)
    else $error("cleared transaction carries a nonzero slot");

endmodule

`default_nettype wire

// ===== src/linear_probe_lookup_or_insert.sv =====
`default_nettype none

// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   kind_i, key_i
// output    out_valid_o / out_ready_i slot_o, status_o
//
// The front reduces the key to its home slot by a reciprocal multiplication
// whose steps are the partial product, the quotient and the remainder; a
// clear transaction skips the reduction.
// The back probes one slot at a time (read of the key store, then compare),
// and a full table walks all TABLE_SLOTS slots. A clear writes one slot per
// cycle. After reset the same pass clears every slot, during which in_ready_o
// stays low. A two-entry queue between front and back and a result register
// on the output let either side stall alone.

module linear_probe_lookup_or_insert #(
  parameter int TABLE_SLOTS = lpl_pkg::DEF_TABLE_SLOTS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [lpl_pkg::KEY_W-1:0]     key_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [lpl_pkg::SLOT_W-1:0]         slot_o,
  output logic [lpl_pkg::STATUS_W-1:0]       status_o
);

  localparam int SW = $clog2(TABLE_SLOTS);
  // A queued transaction carries its kind, its key and its home slot.
  localparam int QW = 1 + lpl_pkg::KEY_W + SW;

  logic          init_busy;
  logic          q_push, q_full, q_pop, q_valid;
  logic [QW-1:0] q_wdata, q_rdata;

  // Front: accepts transactions and computes the home slot.
  lpl_front #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .init_busy_i (init_busy),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  lpl_queue #(
    .WIDTH(QW),
    .DEPTH(lpl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // Back: owns the key store, runs the probe walk and the clearing pass.
  lpl_back #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .slot_o      (slot_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire
